FILE: hdl/pointer_event_conditioner_core_macros.svh
// Assertion macros used by the pointer event conditioner RTL.
`ifndef POINTER_EVENT_CONDITIONER_CORE_MACROS_SVH
`define POINTER_EVENT_CONDITIONER_CORE_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while in reset.
`define PEC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pointer event conditioner: same-cycle check failed");

// Next-cycle implication, checked on clk and disabled while in reset.
`define PEC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pointer event conditioner: next-cycle check failed");

`endif

FILE: hdl/pec_pkg.sv
// Package with types, codes and constants of the pointer event conditioner.
package pec_pkg;

	// Default structural parameters.
	localparam int TIME_BITS_DEF  = 32;
	localparam int COORD_BITS_DEF = 16;

	// Event kinds carried on the input tuser.
	typedef enum logic [1:0] {
		OP_MOVE    = 2'd0,
		OP_PRESS   = 2'd1,
		OP_DCLICK  = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	// Button codes.
	localparam logic [1:0] BTN_LEFT   = 2'd0;
	localparam logic [1:0] BTN_RIGHT  = 2'd1;
	localparam logic [1:0] BTN_MIDDLE = 2'd2;
	localparam logic [1:0] BTN_NONE   = 2'd3;

	// Button mask bits.
	localparam logic [2:0] MASK_LEFT   = 3'h1;
	localparam logic [2:0] MASK_RIGHT  = 3'h2;
	localparam logic [2:0] MASK_MIDDLE = 3'h4;

	// Throttle modes.
	localparam logic [1:0] MODE_FAST  = 2'd1;
	localparam logic [1:0] MODE_ADAPT = 2'd2;

	// Move intervals in milliseconds.
	localparam logic [3:0] IVL_SLOW = 4'd10;
	localparam logic [3:0] IVL_FAST = 4'd5;
	localparam logic [3:0] IVL_MIN  = 4'd2;

	// Distances at or above this limit give the shortest interval.
	localparam int ADAPT_LIMIT = 24;

	// Adaptive interval, 10 - dist/3 clamped at 2, indexed by distance.
	localparam logic [3:0] ADAPT_IVL [32] = '{
		4'd10, 4'd10, 4'd10, 4'd9, 4'd9, 4'd9, 4'd8, 4'd8,
		4'd8,  4'd7,  4'd7,  4'd7, 4'd6, 4'd6, 4'd6, 4'd5,
		4'd5,  4'd5,  4'd4,  4'd4, 4'd4, 4'd3, 4'd3, 4'd3,
		4'd2,  4'd2,  4'd2,  4'd2, 4'd2, 4'd2, 4'd2, 4'd2
	};

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_THROTTLE_MODE = 3'd0,
		REG_DC_WINDOW     = 3'd1,
		REG_DC_BOX        = 3'd2,
		REG_MOVE_LOCK     = 3'd3,
		REG_AREA_WIDTH    = 3'd4,
		REG_AREA_HEIGHT   = 3'd5
	} reg_idx_t;

	// Register reset values.
	localparam logic [1:0]  RST_THROTTLE_MODE = 2'd0;
	localparam logic [15:0] RST_DC_WINDOW     = 16'd500;
	localparam logic [7:0]  RST_DC_BOX        = 8'd4;
	localparam logic [15:0] RST_MOVE_LOCK     = 16'd100;
	localparam logic [15:0] RST_AREA_WIDTH    = 16'd1920;
	localparam logic [15:0] RST_AREA_HEIGHT   = 16'd1080;

	// Settings that steer the event engine.
	typedef struct packed {
		logic [1:0]  throttle_mode;
		logic [15:0] dc_window;
		logic [7:0]  dc_box;
		logic [15:0] move_lock;
	} cfg_t;

	// Outcome of one event from the engine.
	typedef struct packed {
		logic fire;
		logic changed;
	} eng_res_t;

	// Mask bit of a button code; the code for no button has none.
	function automatic logic [2:0] button_bit(input logic [1:0] code);
		logic [2:0] m;
		case (code)
			BTN_LEFT:   m = MASK_LEFT;
			BTN_RIGHT:  m = MASK_RIGHT;
			BTN_MIDDLE: m = MASK_MIDDLE;
			default:    m = 3'h0;
		endcase
		return m;
	endfunction

endpackage

FILE: hdl/pec_engine.sv
// Event engine: click, lock and throttle state with the single-pass decision logic.
module pec_engine
	import pec_pkg::*;
#(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  logic                         commit,
	input  op_t                          op,
	input  logic [1:0]                   button_code,
	input  logic signed [COORD_BITS-1:0] pointer_x,
	input  logic signed [COORD_BITS-1:0] pointer_y,
	input  logic [TIME_BITS-1:0]         now_ms,
	output eng_res_t                     res,
	output logic signed [COORD_BITS-1:0] res_x,
	output logic signed [COORD_BITS-1:0] res_y,
	output logic [2:0]                   res_buttons
);

	// Magnitude of the difference of two coordinates.
	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		if (d < 0) begin
			d = -d;
		end
		return d[COORD_BITS-1:0];
	endfunction

	// State registers.
	logic [2:0]                   held_q;
	logic signed [COORD_BITS-1:0] click_x_q, click_y_q;
	logic [TIME_BITS-1:0]         click_time_q;
	logic                         click_valid_q;
	logic [1:0]                   click_btn_q;
	logic signed [COORD_BITS-1:0] sent_x_q, sent_y_q;
	logic [TIME_BITS-1:0]         thr_time_q;
	logic                         thr_valid_q;
	logic signed [COORD_BITS-1:0] pend_x_q, pend_y_q;

	// Next-state values.
	logic [2:0]                   held_n;
	logic signed [COORD_BITS-1:0] click_x_n, click_y_n;
	logic [TIME_BITS-1:0]         click_time_n;
	logic                         click_valid_n;
	logic [1:0]                   click_btn_n;
	logic signed [COORD_BITS-1:0] sent_x_n, sent_y_n;
	logic [TIME_BITS-1:0]         thr_time_n;
	logic                         thr_valid_n;
	logic signed [COORD_BITS-1:0] pend_x_n, pend_y_n;

	logic [2:0]           bit_m;
	logic [TIME_BITS-1:0] el_click, el_thr;
	logic                 lock, dbl, active, force_out, changed;
	logic [COORD_BITS:0]  move_dist;
	logic [3:0]           ivl;

	// Elapsed times wrap with the timestamp width.
	assign bit_m    = button_bit(button_code);
	assign el_click = now_ms - click_time_q;
	assign el_thr   = now_ms - thr_time_q;

	// Move lock after a release, and the double-click test for a press.
	assign lock = (held_q == 3'h0) && click_valid_q &&
		(el_click < TIME_BITS'(cfg.move_lock));
	assign dbl = (click_btn_q == button_code) && click_valid_q &&
		(el_click < TIME_BITS'(cfg.dc_window)) &&
		(abs_diff(pointer_x, click_x_q) <= COORD_BITS'(cfg.dc_box)) &&
		(abs_diff(pointer_y, click_y_q) <= COORD_BITS'(cfg.dc_box));

	// Event decoding and state update except the throttle.
	always_comb begin
		held_n        = held_q;
		click_x_n     = click_x_q;
		click_y_n     = click_y_q;
		click_time_n  = click_time_q;
		click_valid_n = click_valid_q;
		click_btn_n   = click_btn_q;
		pend_x_n      = pend_x_q;
		pend_y_n      = pend_y_q;
		active        = 1'b1;
		force_out     = 1'b1;
		changed       = 1'b0;
		case (op)
			OP_MOVE: begin
				force_out = 1'b0;
				pend_x_n  = lock ? click_x_q : pointer_x;
				pend_y_n  = lock ? click_y_q : pointer_y;
			end
			OP_PRESS: begin
				if (dbl) begin
					pend_x_n = click_x_q;
					pend_y_n = click_y_q;
				end else begin
					click_x_n   = pointer_x;
					click_y_n   = pointer_y;
					click_btn_n = button_code;
					pend_x_n    = pointer_x;
					pend_y_n    = pointer_y;
				end
				click_time_n  = now_ms;
				click_valid_n = 1'b1;
				held_n        = held_q | bit_m;
				changed       = |bit_m;
			end
			OP_DCLICK: begin
				if ((held_q & bit_m) != 3'h0) begin
					active = 1'b0;
				end else begin
					pend_x_n = pointer_x;
					pend_y_n = pointer_y;
					held_n   = held_q | bit_m;
					changed  = |bit_m;
				end
			end
			OP_RELEASE: begin
				if ((held_q & bit_m) == 3'h0) begin
					active = 1'b0;
				end else begin
					click_x_n     = pointer_x;
					click_y_n     = pointer_y;
					click_time_n  = now_ms;
					click_valid_n = 1'b1;
					held_n        = held_q & ~bit_m;
					pend_x_n      = pointer_x;
					pend_y_n      = pointer_y;
					changed       = 1'b1;
				end
			end
			default: begin
				active = 1'b0;
			end
		endcase
	end

	// Move interval from the throttle mode.
	assign move_dist = {1'b0, abs_diff(pend_x_n, sent_x_q)} +
		{1'b0, abs_diff(pend_y_n, sent_y_q)};

	always_comb begin
		if (cfg.throttle_mode == MODE_FAST) begin
			ivl = IVL_FAST;
		end else if (cfg.throttle_mode == MODE_ADAPT) begin
			if (move_dist < (COORD_BITS+1)'(ADAPT_LIMIT)) begin
				ivl = ADAPT_IVL[move_dist[4:0]];
			end else begin
				ivl = IVL_MIN;
			end
		end else begin
			ivl = IVL_SLOW;
		end
	end

	// Report decision and throttle update.
	assign res.fire    = active && (force_out || !thr_valid_q || (el_thr > TIME_BITS'(ivl)));
	assign res.changed = changed;

	always_comb begin
		thr_time_n  = thr_time_q;
		thr_valid_n = thr_valid_q;
		sent_x_n    = sent_x_q;
		sent_y_n    = sent_y_q;
		if (res.fire) begin
			thr_time_n  = now_ms;
			thr_valid_n = 1'b1;
			sent_x_n    = pend_x_n;
			sent_y_n    = pend_y_n;
		end
	end

	assign res_x       = pend_x_n;
	assign res_y       = pend_y_n;
	assign res_buttons = held_n;

	// State registers take the next values when an event commits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q        <= 3'h0;
			click_x_q     <= '0;
			click_y_q     <= '0;
			click_time_q  <= '0;
			click_valid_q <= 1'b0;
			click_btn_q   <= BTN_NONE;
			sent_x_q      <= '0;
			sent_y_q      <= '0;
			thr_time_q    <= '0;
			thr_valid_q   <= 1'b0;
			pend_x_q      <= '0;
			pend_y_q      <= '0;
		end else if (commit) begin
			held_q        <= held_n;
			click_x_q     <= click_x_n;
			click_y_q     <= click_y_n;
			click_time_q  <= click_time_n;
			click_valid_q <= click_valid_n;
			click_btn_q   <= click_btn_n;
			sent_x_q      <= sent_x_n;
			sent_y_q      <= sent_y_n;
			thr_time_q    <= thr_time_n;
			thr_valid_q   <= thr_valid_n;
			pend_x_q      <= pend_x_n;
			pend_y_q      <= pend_y_n;
		end
	end

endmodule

FILE: hdl/pointer_event_conditioner_core.sv
// Top level of the pointer event conditioner: stream ports, register file and result register.
// A report passes from the event register through the engine into the result register.
// Throughput: one event per cycle while the output is not stalled; the event register
// feeds the engine, which commits its state and loads the result register in the same cycle.
// Events that are dropped or throttled give no report and never wait in the event register.
// Reset clears the valid flags and engine state at once and loads the register defaults; no clearing pass.
`include "pointer_event_conditioner_core_macros.svh"

module pointer_event_conditioner_core
	import pec_pkg::*;
#(
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int S_DATA_BITS = ((2 + 2*COORD_BITS + TIME_BITS + 7) / 8) * 8,
	localparam int M_DATA_BITS = ((2*COORD_BITS + 3 + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata fields from bit 0: button_code, pointer_x, pointer_y, now_ms, zero fill.
	input  logic [S_DATA_BITS-1:0] s_axis_tdata,
	// tuser fields from bit 0: opcode.
	input  logic [1:0]             s_axis_tuser,
	// Output stream.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tdata fields from bit 0: report_x, report_y, button_state, zero fill.
	output logic [M_DATA_BITS-1:0] m_axis_tdata,
	// tuser fields from bit 0: buttons_changed.
	output logic                   m_axis_tuser,
	// Configuration port.
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	// Configuration registers.
	logic [1:0]  throttle_mode_q;
	logic [15:0] dc_window_q;
	logic [7:0]  dc_box_q;
	logic [15:0] move_lock_q;
	logic [15:0] area_width_q;
	logic [15:0] area_height_q;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;
	cfg_t        cfg;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_mode_q <= RST_THROTTLE_MODE;
			dc_window_q     <= RST_DC_WINDOW;
			dc_box_q        <= RST_DC_BOX;
			move_lock_q     <= RST_MOVE_LOCK;
			area_width_q    <= RST_AREA_WIDTH;
			area_height_q   <= RST_AREA_HEIGHT;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_THROTTLE_MODE: throttle_mode_q <= pwdata[1:0];
				REG_DC_WINDOW:     dc_window_q     <= pwdata[15:0];
				REG_DC_BOX:        dc_box_q        <= pwdata[7:0];
				REG_MOVE_LOCK:     move_lock_q     <= pwdata[15:0];
				REG_AREA_WIDTH:    area_width_q    <= pwdata[15:0];
				REG_AREA_HEIGHT:   area_height_q   <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (cfg_idx)
			REG_THROTTLE_MODE: prdata = {30'd0, throttle_mode_q};
			REG_DC_WINDOW:     prdata = {16'd0, dc_window_q};
			REG_DC_BOX:        prdata = {24'd0, dc_box_q};
			REG_MOVE_LOCK:     prdata = {16'd0, move_lock_q};
			REG_AREA_WIDTH:    prdata = {16'd0, area_width_q};
			REG_AREA_HEIGHT:   prdata = {16'd0, area_height_q};
			default:           prdata = 32'd0;
		endcase
	end

	assign cfg.throttle_mode = throttle_mode_q;
	assign cfg.dc_window     = dc_window_q;
	assign cfg.dc_box        = dc_box_q;
	assign cfg.move_lock     = move_lock_q;

	// Event register.
	logic                         ev_valid_s1;
	op_t                          ev_op_s1;
	logic [1:0]                   ev_btn_s1;
	logic signed [COORD_BITS-1:0] ev_x_s1, ev_y_s1;
	logic [TIME_BITS-1:0]         ev_now_s1;
	logic                         ev_go;
	logic                         s_acc;

	// Engine outputs.
	eng_res_t                     res;
	logic signed [COORD_BITS-1:0] res_x, res_y;
	logic [2:0]                   res_buttons;

	// Result register.
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
	logic [2:0]                   out_buttons_q;
	logic                         out_changed_q;

	// The event moves on unless it has a report and the result register is full and not being read.
	assign ev_go         = ev_valid_s1 && (!res.fire || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !ev_valid_s1 || ev_go;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			ev_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			ev_op_s1  <= op_t'(s_axis_tuser);
			ev_btn_s1 <= s_axis_tdata[1:0];
			ev_x_s1   <= s_axis_tdata[2 +: COORD_BITS];
			ev_y_s1   <= s_axis_tdata[2 + COORD_BITS +: COORD_BITS];
			ev_now_s1 <= s_axis_tdata[2 + 2*COORD_BITS +: TIME_BITS];
		end
	end

	pec_engine #(
		.TIME_BITS  (TIME_BITS),
		.COORD_BITS (COORD_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.commit      (ev_go),
		.op          (ev_op_s1),
		.button_code (ev_btn_s1),
		.pointer_x   (ev_x_s1),
		.pointer_y   (ev_y_s1),
		.now_ms      (ev_now_s1),
		.res         (res),
		.res_x       (res_x),
		.res_y       (res_y),
		.res_buttons (res_buttons)
	);

	// Result register: loads a report, clears when the report is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ev_go && res.fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_go && res.fire) begin
			out_x_q       <= res_x;
			out_y_q       <= res_y;
			out_buttons_q <= res_buttons;
			out_changed_q <= res.changed;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_DATA_BITS'({out_buttons_q, out_y_q, out_x_q});
	assign m_axis_tuser  = out_changed_q;

	// A committed report is on the output in the next cycle.
	`PEC_ASSERT_NEXT(a_report_loads, ev_go && res.fire, m_axis_tvalid)
	// Move reports never flag a button change.
	`PEC_ASSERT_NEXT(a_move_unchanged, ev_go && res.fire && (ev_op_s1 == OP_MOVE), !m_axis_tuser)
	// A report that cannot be placed keeps its event in the event register.
	`PEC_ASSERT_NEXT(a_event_held, ev_valid_s1 && res.fire && out_valid_q && !m_axis_tready, ev_valid_s1 && $stable(ev_now_s1))

endmodule

FILE: verif/pointer_event_conditioner_core_checker.sv
`timescale 1ns / 1ps
// Checker that predicts and compares the reports of the pointer event conditioner.
module pointer_event_conditioner_core_checker
	import pec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// Fields from bit 0: button_code, pointer_x, pointer_y, now_ms, zero fill.
	input  logic [71:0] s_tdata,
	// Fields from bit 0: opcode.
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: report_x, report_y, button_state, zero fill.
	input  logic [39:0] m_tdata,
	// Fields from bit 0: buttons_changed.
	input  logic        m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          failures,
	output int          pending_reports
);

	localparam int SLOW_MS  = 10;
	localparam int FAST_MS  = 5;
	localparam int FLOOR_MS = 2;
	localparam int SHOWN_FAILURES = 10;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [2:0]         buttons;
		logic               changed;
	} report_t;

	report_t awaited_reports[$];
	int      mismatch_count;

	// Register copies.
	logic [1:0]  cfg_mode;
	logic [15:0] cfg_window;
	logic [7:0]  cfg_box;
	logic [15:0] cfg_lock;
	logic [15:0] cfg_width;
	logic [15:0] cfg_height;

	// Conditioner state.
	logic [2:0]         held;
	logic signed [15:0] click_x;
	logic signed [15:0] click_y;
	logic [31:0]        click_stamp;
	bit                 click_armed;
	logic [1:0]         click_btn;
	logic signed [15:0] sent_x;
	logic signed [15:0] sent_y;
	logic [31:0]        throttle_stamp;
	bit                 throttle_armed;
	logic signed [15:0] pend_x;
	logic signed [15:0] pend_y;

	function automatic int span(input logic signed [15:0] a, input logic signed [15:0] b);
		int d;
		d = int'(a) - int'(b);
		return (d < 0) ? -d : d;
	endfunction

	function automatic logic [2:0] mask_of(input logic [1:0] code);
		case (code)
			BTN_LEFT:   return MASK_LEFT;
			BTN_RIGHT:  return MASK_RIGHT;
			BTN_MIDDLE: return MASK_MIDDLE;
			default:    return 3'b000;
		endcase
	endfunction

	task automatic clear_state();
		cfg_mode       = RST_THROTTLE_MODE;
		cfg_window     = RST_DC_WINDOW;
		cfg_box        = RST_DC_BOX;
		cfg_lock       = RST_MOVE_LOCK;
		cfg_width      = RST_AREA_WIDTH;
		cfg_height     = RST_AREA_HEIGHT;
		held           = 3'b000;
		click_x        = '0;
		click_y        = '0;
		click_stamp    = '0;
		click_armed    = 1'b0;
		click_btn      = BTN_NONE;
		sent_x         = '0;
		sent_y         = '0;
		throttle_stamp = '0;
		throttle_armed = 1'b0;
		pend_x         = '0;
		pend_y         = '0;
		awaited_reports.delete();
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
		case (reg_idx_t'(idx))
			REG_THROTTLE_MODE: cfg_mode   = data[1:0];
			REG_DC_WINDOW:     cfg_window = data[15:0];
			REG_DC_BOX:        cfg_box    = data[7:0];
			REG_MOVE_LOCK:     cfg_lock   = data[15:0];
			REG_AREA_WIDTH:    cfg_width  = data[15:0];
			REG_AREA_HEIGHT:   cfg_height = data[15:0];
			default: ;
		endcase
	endtask

	// Sends the pending position unless a move comes before its interval has passed.
	task automatic issue_report(input logic [31:0] now, input bit forced, input bit changed);
		int          interval;
		logic [31:0] since;
		report_t     rep;
		interval = SLOW_MS;
		if (cfg_mode == MODE_FAST) begin
			interval = FAST_MS;
		end else if (cfg_mode == MODE_ADAPT) begin
			interval = SLOW_MS - (span(pend_x, sent_x) + span(pend_y, sent_y)) / 3;
			if (interval < FLOOR_MS) begin
				interval = FLOOR_MS;
			end
		end
		since = now - throttle_stamp;
		if (!forced && throttle_armed && since <= 32'(interval)) begin
			return;
		end
		throttle_stamp = now;
		throttle_armed = 1'b1;
		sent_x = pend_x;
		sent_y = pend_y;
		rep.x = pend_x;
		rep.y = pend_y;
		rep.buttons = held;
		rep.changed = changed;
		awaited_reports.push_back(rep);
	endtask

	// Applies one accepted event to the state and queues the report it causes.
	task automatic condition_event(input op_t op, input logic [1:0] btn,
			input logic signed [15:0] x, input logic signed [15:0] y, input logic [31:0] now);
		logic [2:0]  bit_m;
		logic [31:0] since_click;
		bit          repeat_click;
		bit_m = mask_of(btn);
		since_click = now - click_stamp;
		case (op)
			OP_MOVE: begin
				// Right after a release with nothing held, moves stick to the click point.
				if (held == 3'b000 && click_armed && since_click < {16'h0, cfg_lock}) begin
					pend_x = click_x;
					pend_y = click_y;
				end else begin
					pend_x = x;
					pend_y = y;
				end
				issue_report(now, 1'b0, 1'b0);
			end
			OP_PRESS: begin
				repeat_click = (click_btn == btn) && click_armed &&
					since_click < {16'h0, cfg_window} &&
					span(x, click_x) <= int'(cfg_box) && span(y, click_y) <= int'(cfg_box);
				if (repeat_click) begin
					pend_x = click_x;
					pend_y = click_y;
				end else begin
					click_x = x;
					click_y = y;
					click_btn = btn;
					pend_x = x;
					pend_y = y;
				end
				click_stamp = now;
				click_armed = 1'b1;
				held = held | bit_m;
				issue_report(now, 1'b1, bit_m != 3'b000);
			end
			OP_DCLICK: begin
				// A double-click press of a button already held is dropped.
				if ((held & bit_m) == 3'b000) begin
					pend_x = x;
					pend_y = y;
					held = held | bit_m;
					issue_report(now, 1'b1, bit_m != 3'b000);
				end
			end
			default: begin
				// A release of a button that is not held is dropped.
				if ((held & bit_m) != 3'b000) begin
					click_x = x;
					click_y = y;
					click_stamp = now;
					click_armed = 1'b1;
					held = held & ~bit_m;
					pend_x = x;
					pend_y = y;
					issue_report(now, 1'b1, 1'b1);
				end
			end
		endcase
	endtask

	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= SHOWN_FAILURES) begin
			$display("%s", msg);
		end
	endtask

	task automatic check_report(input logic [39:0] data, input logic changed);
		report_t            want;
		logic signed [15:0] got_x;
		logic signed [15:0] got_y;
		logic [2:0]         got_buttons;
		got_x = data[15:0];
		got_y = data[31:16];
		got_buttons = data[34:32];
		if (awaited_reports.size() == 0) begin
			note_failure($sformatf("report x=%0d y=%0d buttons=%03b changed=%0b with none awaited",
				got_x, got_y, got_buttons, changed));
			return;
		end
		want = awaited_reports.pop_front();
		if (got_x !== want.x || got_y !== want.y || got_buttons !== want.buttons ||
				changed !== want.changed) begin
			note_failure($sformatf(
				"report mismatch: expected x=%0d y=%0d buttons=%03b changed=%0b, got x=%0d y=%0d buttons=%03b changed=%0b",
				want.x, want.y, want.buttons, want.changed, got_x, got_y, got_buttons, changed));
		end
	endtask

	// Watch the register port and both streams on every rising edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (psel && penable && pwrite && pready) begin
				write_register(paddr[4:2], pwdata);
			end
			if (s_tvalid && s_tready) begin
				condition_event(op_t'(s_tuser), s_tdata[1:0], s_tdata[17:2], s_tdata[33:18],
					s_tdata[65:34]);
			end
			if (m_tvalid && m_tready) begin
				check_report(m_tdata, m_tuser);
			end
		end
		failures <= mismatch_count;
		pending_reports <= awaited_reports.size();
	end

endmodule

FILE: verif/pointer_event_conditioner_core_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the pointer event conditioner core.
module pointer_event_conditioner_core_test;
	import pec_pkg::*;

	localparam logic [1:0] MODE_SLOW     = 2'd0;
	localparam logic [1:0] MODE_SLOW_ALT = 2'd3;
	localparam int PHASE_EVENTS   = 200;
	localparam int SQUEEZE_EVENTS = 80;
	localparam int SQUEEZE_CYCLES = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int CYCLE_LIMIT    = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// Fields from bit 0: button_code, pointer_x, pointer_y, now_ms, zero fill.
	logic [71:0] s_axis_tdata = '0;
	// Fields from bit 0: opcode.
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// Fields from bit 0: report_x, report_y, button_state, zero fill.
	logic [39:0] m_axis_tdata;
	// Fields from bit 0: buttons_changed.
	logic        m_axis_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int failures;
	int pending_reports;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	bit squeeze_req = 1'b0;
	bit squeezed = 1'b0;
	int hold_left = 0;

	logic [31:0]        stamp_ms = '0;
	logic signed [15:0] pos_x = '0;
	logic signed [15:0] pos_y = '0;

	always #5 clk = ~clk;

	pointer_event_conditioner_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pointer_event_conditioner_core_checker watch (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
		.s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
		.m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.failures(failures), .pending_reports(pending_reports)
	);

	// Offers one request on the input stream and returns at the falling edge after it is taken.
	task automatic send_event(input op_t op, input logic [1:0] btn, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic [31:0] now);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'b0, now, y, x, btn};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_registers(input logic [1:0] mode, input logic [15:0] window,
			input logic [7:0] box, input logic [15:0] lock, input logic [15:0] width,
			input logic [15:0] height);
		apb_write(REG_THROTTLE_MODE, {30'd0, mode});
		apb_write(REG_DC_WINDOW, {16'd0, window});
		apb_write(REG_DC_BOX, {24'd0, box});
		apb_write(REG_MOVE_LOCK, {16'd0, lock});
		apb_write(REG_AREA_WIDTH, {16'd0, width});
		apb_write(REG_AREA_HEIGHT, {16'd0, height});
	endtask

	// Drains the block: waits until all awaited reports are in, then lets events that give none settle.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_reports != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Hand-picked events under the reset settings.
	task automatic directed_events();
		send_event(OP_MOVE, BTN_LEFT, 16'sd100, 16'sd200, 32'd1000);
		// Too soon after the last move report, so it is throttled.
		send_event(OP_MOVE, BTN_LEFT, 16'sd101, 16'sd201, 32'd1005);
		send_event(OP_MOVE, BTN_NONE, 16'sh8000, 16'sh7FFF, 32'd1020);
		send_event(OP_PRESS, BTN_LEFT, 16'sd50, 16'sd60, 32'd1100);
		send_event(OP_RELEASE, BTN_LEFT, 16'sd50, 16'sd60, 32'd1150);
		// Inside the lock window after a release the move sticks to the click.
		send_event(OP_MOVE, BTN_LEFT, 16'sd300, 16'sd300, 32'd1170);
		// Same button, close in time and place: a double click.
		send_event(OP_PRESS, BTN_LEFT, 16'sd52, 16'sd58, 32'd1200);
		send_event(OP_DCLICK, BTN_LEFT, 16'sd52, 16'sd58, 32'd1210);
		send_event(OP_RELEASE, BTN_LEFT, 16'sd52, 16'sd58, 32'd1220);
		send_event(OP_RELEASE, BTN_LEFT, 16'sd52, 16'sd58, 32'd1230);
		// The no-button code leaves the held buttons as they are.
		send_event(OP_PRESS, BTN_NONE, 16'sd10, 16'sd10, 32'd1300);
		send_event(OP_DCLICK, BTN_NONE, 16'sd20, 16'sd20, 32'd1310);
		send_event(OP_RELEASE, BTN_NONE, 16'sd20, 16'sd20, 32'd1320);
		send_event(OP_PRESS, BTN_RIGHT, 16'sh7FFF, 16'sh8000, 32'd1400);
		send_event(OP_PRESS, BTN_MIDDLE, -16'sd5, -16'sd7, 32'd1410);
		send_event(OP_DCLICK, BTN_LEFT, 16'sd0, 16'sd0, 32'd1420);
		send_event(OP_MOVE, BTN_LEFT, 16'sd5, 16'sd5, 32'd1425);
		send_event(OP_MOVE, BTN_RIGHT, 16'sd6, 16'sd6, 32'd1440);
		send_event(OP_RELEASE, BTN_RIGHT, 16'sd6, 16'sd6, 32'd1450);
		send_event(OP_RELEASE, BTN_MIDDLE, 16'sd6, 16'sd6, 32'd1460);
		send_event(OP_RELEASE, BTN_LEFT, 16'sd6, 16'sd6, 32'd1470);
		// Timestamps wrap through zero.
		send_event(OP_MOVE, BTN_MIDDLE, 16'sd900, 16'sd900, 32'hFFFF_FFFF);
		send_event(OP_MOVE, BTN_MIDDLE, 16'sd901, 16'sd901, 32'd9);
		send_event(OP_MOVE, BTN_MIDDLE, 16'sd902, 16'sd902, 32'd12);
		send_event(OP_PRESS, BTN_LEFT, 16'sd902, 16'sd902, 32'd0);
	endtask

	// Coherent pointer traffic with some fully random requests mixed in.
	task automatic random_events(input int count);
		int         n;
		int         pick;
		int         jump;
		op_t        op;
		logic [1:0] btn;
		stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 8) begin
				send_event(op_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 16'($urandom),
					16'($urandom), $urandom);
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					stamp_ms = stamp_ms + $urandom_range(0, 12);
				end else if (pick < 9) begin
					stamp_ms = stamp_ms + $urandom_range(0, 700);
				end else begin
					stamp_ms = stamp_ms + $urandom_range(0, 70000);
				end
				jump = ($urandom_range(0, 4) == 0) ? 40 : 6;
				pos_x = pos_x + 16'(int'($urandom_range(0, jump)) - jump / 2);
				pos_y = pos_y + 16'(int'($urandom_range(0, jump)) - jump / 2);
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					op = OP_MOVE;
				end else if (pick < 65) begin
					op = OP_PRESS;
				end else if (pick < 75) begin
					op = OP_DCLICK;
				end else begin
					op = OP_RELEASE;
				end
				btn = ($urandom_range(0, 9) == 0) ? BTN_NONE : 2'($urandom_range(0, 2));
				send_event(op, btn, pos_x, pos_y, stamp_ms);
			end
		end
	endtask

	// Output side: random hold-offs plus one long stall on request.
	initial begin
		forever begin
			@(negedge clk);
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				hold_left = SQUEEZE_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL pointer_event_conditioner_core");
		$finish;
	end

	initial begin
		int phase;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		src_idle_pct = 28;
		sink_idle_pct <= 78;
		directed_events();
		for (phase = 0; phase < 6; phase++) begin
			settle();
			case (phase)
				0: program_registers(MODE_FAST, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				1: program_registers(MODE_ADAPT, 16'd0, 8'd0, 16'd0, 16'd1, 16'd1);
				2: program_registers(MODE_SLOW_ALT, 16'd300, 8'd8, 16'd50, 16'd1920, 16'd1080);
				3: program_registers(MODE_ADAPT, 16'd800, 8'd20, 16'd250, 16'd640, 16'd480);
				4: program_registers(MODE_SLOW, 16'($urandom_range(0, 1000)),
					8'($urandom_range(0, 30)), 16'($urandom_range(0, 400)),
					16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
				default: program_registers(MODE_ADAPT, RST_DC_WINDOW, RST_DC_BOX, RST_MOVE_LOCK,
					RST_AREA_WIDTH, RST_AREA_HEIGHT);
			endcase
			if (phase == 2) begin
				src_idle_pct = 78;
				sink_idle_pct <= 28;
			end else if (phase == 4) begin
				src_idle_pct = 0;
				sink_idle_pct <= 0;
			end
			random_events(PHASE_EVENTS);
		end
		// Keep offering while the output side stalls so the block backs up.
		squeeze_req <= 1'b1;
		random_events(SQUEEZE_EVENTS);
		s_axis_tvalid <= 1'b0;
		while (pending_reports != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0) begin
			$display("PASS pointer_event_conditioner_core");
		end else begin
			$display("FAIL pointer_event_conditioner_core");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/pec_pkg.sv
hdl/pec_engine.sv
hdl/pointer_event_conditioner_core.sv
verif/pointer_event_conditioner_core_checker.sv
verif/pointer_event_conditioner_core_test.sv
